FILE: rtl/fac_pkg.sv
// ----------------------------------------------------------------------------
// fac_pkg: shared types and constants for the frame allocator
// Frame counts, chunk geometry for the free scan, request codes and the
// chunk scan result record.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int FRAME_W    = 6;
  localparam int CNT_W      = 7;

  localparam int CHUNK      = 8;
  localparam int LOW_W      = $clog2(CHUNK);
  localparam int NUM_CHUNKS = NUM_FRAMES / CHUNK;
  localparam int CHUNK_W    = FRAME_W - LOW_W;
  localparam int POP_W      = $clog2(CHUNK + 1);

  localparam logic [CNT_W-1:0] CFG_RESET = CNT_W'(NUM_FRAMES);

  localparam logic REQ_ALLOC  = 1'b0;
  localparam logic REQ_ACCESS = 1'b1;

  typedef struct packed {
    logic [POP_W-1:0] cnt;
    logic             any;
    logic [LOW_W-1:0] low;
  } chunk_res_t;

endpackage

FILE: rtl/frame_allocator_enhanced_clock_core.sv
// ----------------------------------------------------------------------------
// frame_allocator_enhanced_clock_core: frame allocator, enhanced clock
// Free bitmap with use and modify bits per frame; lowest-free allocation and
// enhanced second-chance victim selection from a kept hand.
// ----------------------------------------------------------------------------
// Each request is taken only while the sequencer is idle and is worked one
// at a time. Every request first walks the free bitmap eight frames per cycle
// through one shared chunk scanner, then a decide state loads the result
// register and a response state moves it to the output register once that
// is free, for an access or for an allocation that finds a free frame. An
// allocation with no free frame instead walks the clock one frame per cycle
// before the response state. All frame bits reset at once, so the block is
// ready in the cycle after reset.
// ----------------------------------------------------------------------------
module frame_allocator_enhanced_clock_core (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         cfg_we,
  input  logic [fac_pkg::CNT_W-1:0]    cfg_wdata,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [fac_pkg::FRAME_W-1:0]  in_frame,
  input  logic                         in_is_write,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fac_pkg::FRAME_W-1:0]  out_frame_index,
  output logic                         out_from_replacement,
  output logic                         out_victim_dirty,
  output logic                         out_status,
  output logic [fac_pkg::CNT_W-1:0]    out_free_count
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_COUNT  = 5'b00010,
    S_DECIDE = 5'b00100,
    S_CLOCK  = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  localparam int FW = fac_pkg::FRAME_W;
  localparam int CW = fac_pkg::CNT_W;
  localparam int NF = fac_pkg::NUM_FRAMES;

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 cfg_n_r, cfg_n_nxt;
  logic [CW-1:0]                 n_eff;

  logic                          req_r, req_nxt;
  logic [FW-1:0]                 frame_r, frame_nxt;
  logic                          wr_r, wr_nxt;
  logic [CW-1:0]                 n_r, n_nxt;

  logic [fac_pkg::CHUNK_W-1:0]   chunk_r, chunk_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          found_r, found_nxt;
  logic [FW-1:0]                 first_r, first_nxt;

  logic [FW-1:0]                 pos_r, pos_nxt;
  logic [FW-1:0]                 k_r, k_nxt;
  logic                          second_r, second_nxt;
  logic [FW-1:0]                 hand_r, hand_nxt;

  logic [NF-1:0]                 free_map_r, free_map_nxt;
  logic [NF-1:0]                 use_r, use_nxt;
  logic [NF-1:0]                 mod_r, mod_nxt;

  logic [FW-1:0]                 res_idx_r, res_idx_nxt;
  logic                          res_repl_r, res_repl_nxt;
  logic                          res_dirty_r, res_dirty_nxt;
  logic                          res_status_r, res_status_nxt;
  logic [CW-1:0]                 res_free_r, res_free_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [FW-1:0]                 out_idx_r, out_idx_nxt;
  logic                          out_repl_r, out_repl_nxt;
  logic                          out_dirty_r, out_dirty_nxt;
  logic                          out_status_r, out_status_nxt;
  logic [CW-1:0]                 out_free_r, out_free_nxt;

  fac_pkg::chunk_res_t           scan;
  logic [CW-1:0]                 pos_p1;
  logic [FW-1:0]                 pos_wrap;
  logic                          u_bit, m_bit, hit, bad_access, out_free;

  assign n_eff = (cfg_n_r == '0) ? CW'(1) :
                 (cfg_n_r > CW'(NF)) ? CW'(NF) : cfg_n_r;

  fac_chunk_scan u_scan (
    .chunk_idx (chunk_r),
    .free_bits (free_map_r[{chunk_r, fac_pkg::LOW_W'(0)} +: fac_pkg::CHUNK]),
    .n_frames  (n_r),
    .res       (scan)
  );

  assign pos_p1     = {1'b0, pos_r} + CW'(1);
  assign pos_wrap   = (pos_p1 < n_r) ? pos_p1[FW-1:0] : '0;
  assign u_bit      = use_r[pos_r];
  assign m_bit      = mod_r[pos_r];
  assign hit        = !u_bit && (second_r ? m_bit : !m_bit);
  assign bad_access = ({1'b0, frame_r} >= n_r) || free_map_r[frame_r];
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    cfg_n_nxt      = cfg_we ? cfg_wdata : cfg_n_r;
    req_nxt        = req_r;
    frame_nxt      = frame_r;
    wr_nxt         = wr_r;
    n_nxt          = n_r;
    chunk_nxt      = chunk_r;
    cnt_nxt        = cnt_r;
    found_nxt      = found_r;
    first_nxt      = first_r;
    pos_nxt        = pos_r;
    k_nxt          = k_r;
    second_nxt     = second_r;
    hand_nxt       = hand_r;
    free_map_nxt   = free_map_r;
    use_nxt        = use_r;
    mod_nxt        = mod_r;
    res_idx_nxt    = res_idx_r;
    res_repl_nxt   = res_repl_r;
    res_dirty_nxt  = res_dirty_r;
    res_status_nxt = res_status_r;
    res_free_nxt   = res_free_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_idx_nxt    = out_idx_r;
    out_repl_nxt   = out_repl_r;
    out_dirty_nxt  = out_dirty_r;
    out_status_nxt = out_status_r;
    out_free_nxt   = out_free_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          frame_nxt = in_frame;
          wr_nxt    = in_is_write;
          n_nxt     = n_eff;
          chunk_nxt = '0;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          first_nxt = '0;
          state_nxt = S_COUNT;
        end
      end
      S_COUNT: begin
        cnt_nxt = cnt_r + CW'(scan.cnt);
        if (!found_r && scan.any) begin
          found_nxt = 1'b1;
          first_nxt = {chunk_r, scan.low};
        end
        chunk_nxt = chunk_r + 1'b1;
        if (chunk_r == fac_pkg::CHUNK_W'(fac_pkg::NUM_CHUNKS - 1)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_free_nxt  = cnt_r;
        res_repl_nxt  = 1'b0;
        res_dirty_nxt = 1'b0;
        if (req_r == fac_pkg::REQ_ACCESS) begin
          res_idx_nxt    = frame_r;
          res_status_nxt = bad_access;
          if (!bad_access) begin
            use_nxt[frame_r] = 1'b1;
            if (wr_r) begin
              mod_nxt[frame_r] = 1'b1;
            end
          end
          state_nxt = S_RESP;
        end else if (found_r) begin
          res_idx_nxt           = first_r;
          res_status_nxt        = 1'b0;
          res_free_nxt          = cnt_r - CW'(1);
          free_map_nxt[first_r] = 1'b0;
          use_nxt[first_r]      = 1'b1;
          mod_nxt[first_r]      = 1'b0;
          state_nxt             = S_RESP;
        end else begin
          pos_nxt    = ({1'b0, hand_r} < n_r) ? hand_r : '0;
          k_nxt      = '0;
          second_nxt = 1'b0;
          state_nxt  = S_CLOCK;
        end
      end
      S_CLOCK: begin
        if (hit) begin
          res_idx_nxt          = pos_r;
          res_repl_nxt         = 1'b1;
          res_dirty_nxt        = m_bit;
          res_status_nxt       = 1'b0;
          hand_nxt             = pos_wrap;
          free_map_nxt[pos_r]  = 1'b0;
          use_nxt[pos_r]       = 1'b1;
          mod_nxt[pos_r]       = 1'b0;
          state_nxt            = S_RESP;
        end else begin
          if (second_r) begin
            use_nxt[pos_r] = 1'b0;
          end
          pos_nxt = pos_wrap;
          if (({1'b0, k_r} + CW'(1)) == n_r) begin
            k_nxt      = '0;
            second_nxt = !second_r;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = res_idx_r;
          out_repl_nxt   = res_repl_r;
          out_dirty_nxt  = res_dirty_r;
          out_status_nxt = res_status_r;
          out_free_nxt   = res_free_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_n_r     <= fac_pkg::CFG_RESET;
      hand_r      <= '0;
      free_map_r  <= '1;
      use_r       <= '0;
      mod_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_n_r     <= cfg_n_nxt;
      hand_r      <= hand_nxt;
      free_map_r  <= free_map_nxt;
      use_r       <= use_nxt;
      mod_r       <= mod_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    frame_r      <= frame_nxt;
    wr_r         <= wr_nxt;
    n_r          <= n_nxt;
    chunk_r      <= chunk_nxt;
    cnt_r        <= cnt_nxt;
    found_r      <= found_nxt;
    first_r      <= first_nxt;
    pos_r        <= pos_nxt;
    k_r          <= k_nxt;
    second_r     <= second_nxt;
    res_idx_r    <= res_idx_nxt;
    res_repl_r   <= res_repl_nxt;
    res_dirty_r  <= res_dirty_nxt;
    res_status_r <= res_status_nxt;
    res_free_r   <= res_free_nxt;
    out_idx_r    <= out_idx_nxt;
    out_repl_r   <= out_repl_nxt;
    out_dirty_r  <= out_dirty_nxt;
    out_status_r <= out_status_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_frame_index      = out_idx_r;
  assign out_from_replacement = out_repl_r;
  assign out_victim_dirty     = out_dirty_r;
  assign out_status           = out_status_r;
  assign out_free_count       = out_free_r;

  a_clock_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLOCK) |-> (req_r == fac_pkg::REQ_ALLOC && !found_r && cnt_r == '0))
    else $error("clock walk entered with a free frame available");

  a_clock_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLOCK) |-> ({1'b0, pos_r} < n_r && {1'b0, k_r} < n_r))
    else $error("clock position or step count past frame count");

  a_alloc_marks_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && req_r == fac_pkg::REQ_ALLOC && found_r) |=>
      (!free_map_r[$past(first_r)] && use_r[$past(first_r)]))
    else $error("allocated frame not marked used");

  a_repl_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_repl_r || out_dirty_r)) |->
      (!out_status_r && out_free_r == '0))
    else $error("replacement result with bad status or free frames left");

endmodule

FILE: rtl/fac_chunk_scan.sv
// ----------------------------------------------------------------------------
// fac_chunk_scan: free-bit scan of one chunk of frames
// Masks off frames at or past the frame count, then gives the number of free
// frames in the chunk and the lowest free one.
// ----------------------------------------------------------------------------
module fac_chunk_scan (
  input  logic [fac_pkg::CHUNK_W-1:0] chunk_idx,
  input  logic [fac_pkg::CHUNK-1:0]   free_bits,
  input  logic [fac_pkg::CNT_W-1:0]   n_frames,
  output fac_pkg::chunk_res_t         res
);

  logic [fac_pkg::CHUNK-1:0]   masked;
  logic [fac_pkg::FRAME_W-1:0] idx;

  always_comb begin
    masked  = '0;
    idx     = '0;
    res.cnt = '0;
    res.low = '0;
    for (int j = fac_pkg::CHUNK - 1; j >= 0; j--) begin
      idx       = {chunk_idx, fac_pkg::LOW_W'(j)};
      masked[j] = free_bits[j] && ({1'b0, idx} < n_frames);
      res.cnt   = res.cnt + fac_pkg::POP_W'(masked[j]);
      if (masked[j]) begin
        res.low = fac_pkg::LOW_W'(j);
      end
    end
    res.any = |masked;
  end

endmodule

FILE: tb/frame_alloc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_alloc_checker: result predictor and comparator for the frame allocator
// Watches the config port and both channels, keeps its own copy of the free
// map, use and modify bits and clock hand, predicts one result per request
// transfer and compares every result transfer field by field, in order.
// ----------------------------------------------------------------------------
module frame_alloc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [fac_pkg::CNT_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [fac_pkg::FRAME_W-1:0] in_frame,
  input  logic                        in_is_write,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [fac_pkg::FRAME_W-1:0] out_frame_index,
  input  logic                        out_from_replacement,
  input  logic                        out_victim_dirty,
  input  logic                        out_status,
  input  logic [fac_pkg::CNT_W-1:0]   out_free_count,
  output int                          fail_count,
  output int                          pending,
  output int                          result_count,
  output int                          evict_count,
  output int                          dirty_count,
  output int                          reject_count
);

  typedef struct packed {
    logic [fac_pkg::FRAME_W-1:0] frame_index;
    logic                        from_replacement;
    logic                        victim_dirty;
    logic                        status;
    logic [fac_pkg::CNT_W-1:0]   free_count;
  } frame_result_t;

  frame_result_t                   expected_results[$];
  logic [fac_pkg::NUM_FRAMES-1:0]  free_map;
  logic [fac_pkg::NUM_FRAMES-1:0]  use_bits;
  logic [fac_pkg::NUM_FRAMES-1:0]  modify_bits;
  logic [fac_pkg::FRAME_W-1:0]     clock_hand;
  logic [fac_pkg::CNT_W-1:0]       frame_count;

  function automatic int active_frames();
    int n;
    n = frame_count;
    if (n < 1) n = 1;
    if (n > fac_pkg::NUM_FRAMES) n = fac_pkg::NUM_FRAMES;
    if (n > 64) n = 64;
    return n;
  endfunction

  task automatic serve_request(input logic req, input logic [fac_pkg::FRAME_W-1:0] fr,
                               input logic wr, output frame_result_t r);
    int  n, i, f, pos, round, k;
    bit  found;
    n = active_frames();
    r = '0;
    found = 0;
    if (req == fac_pkg::REQ_ALLOC) begin
      for (i = 0; i < n && !found; i++) begin
        if (free_map[i]) begin
          r.frame_index = fac_pkg::FRAME_W'(i);
          found = 1;
        end
      end
      if (!found) begin
        // enhanced clock: even passes want U=0,M=0; odd passes want U=0,M=1
        // and clear U on every frame passed over
        pos = (clock_hand < n) ? int'(clock_hand) : 0;
        for (round = 0; round < 4 && !found; round++) begin
          for (k = 0; k < n && !found; k++) begin
            f = pos;
            pos = (pos + 1 < n) ? pos + 1 : 0;
            if (round % 2 == 0) begin
              if (!use_bits[f] && !modify_bits[f]) begin
                r.frame_index = fac_pkg::FRAME_W'(f);
                found = 1;
              end
            end else begin
              if (!use_bits[f] && modify_bits[f]) begin
                r.frame_index = fac_pkg::FRAME_W'(f);
                found = 1;
              end else begin
                use_bits[f] = 1'b0;
              end
            end
          end
        end
        r.from_replacement = 1'b1;
        r.victim_dirty = modify_bits[r.frame_index];
        clock_hand = (int'(r.frame_index) + 1 < n) ?
                     fac_pkg::FRAME_W'(r.frame_index + 1) : '0;
      end
      free_map[r.frame_index] = 1'b0;
      use_bits[r.frame_index] = 1'b1;
      modify_bits[r.frame_index] = 1'b0;
    end else begin
      r.frame_index = fr;
      if (int'(fr) >= n || free_map[fr]) begin
        r.status = 1'b1;
      end else begin
        use_bits[fr] = 1'b1;
        if (wr) modify_bits[fr] = 1'b1;
      end
    end
    for (i = 0; i < n; i++) r.free_count += fac_pkg::CNT_W'(free_map[i]);
  endtask

  function automatic void check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : sample
    frame_result_t want;
    if (!rst_n) begin
      free_map = '1;
      use_bits = '0;
      modify_bits = '0;
      clock_hand = '0;
      frame_count = fac_pkg::CFG_RESET;
      expected_results.delete();
      pending = 0;
      fail_count = 0;
      result_count = 0;
      evict_count = 0;
      dirty_count = 0;
      reject_count = 0;
    end else begin
      if (cfg_we) frame_count = cfg_wdata;
      if (in_valid && !in_stall) begin
        serve_request(in_req_type, in_frame, in_is_write, want);
        expected_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: frame_index %0d", out_frame_index);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          result_count++;
          if (want.from_replacement) evict_count++;
          if (want.victim_dirty) dirty_count++;
          if (want.status) reject_count++;
          check_field("frame_index", want.frame_index, out_frame_index);
          check_field("from_replacement", want.from_replacement, out_from_replacement);
          check_field("victim_dirty", want.victim_dirty, out_victim_dirty);
          check_field("status", want.status, out_status);
          check_field("free_count", want.free_count, out_free_count);
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

FILE: tb/frame_allocator_enhanced_clock_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_allocator_enhanced_clock_core_test: regression for the frame allocator
// Directed requests over small and clamped frame counts, then random phases
// of mostly valid accesses mixed with allocations that fill the map and
// force clock evictions, with bursty input and a patterned result stall.
// ----------------------------------------------------------------------------
module frame_allocator_enhanced_clock_core_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_PHASES     = 7;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic [fac_pkg::CNT_W-1:0]   cfg_wdata;
  logic                        in_valid;
  logic                        in_stall;
  logic                        in_req_type;
  logic [fac_pkg::FRAME_W-1:0] in_frame;
  logic                        in_is_write;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [fac_pkg::FRAME_W-1:0] out_frame_index;
  logic                        out_from_replacement;
  logic                        out_victim_dirty;
  logic                        out_status;
  logic [fac_pkg::CNT_W-1:0]   out_free_count;

  int fail_count, pending, result_count, evict_count, dirty_count, reject_count;
  int burst_left = 0;
  int settings_done = 0;
  int active_n = fac_pkg::NUM_FRAMES;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int phase_count [NUM_PHASES] = '{64, 2, 0, 127, 17, 1, 64};
  int phase_items [NUM_PHASES] = '{200, 40, 20, 80, 60, 20, 80};

  always #1 clk = ~clk;

  frame_allocator_enhanced_clock_core u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_frame             (in_frame),
    .in_is_write          (in_is_write),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_frame_index      (out_frame_index),
    .out_from_replacement (out_from_replacement),
    .out_victim_dirty     (out_victim_dirty),
    .out_status           (out_status),
    .out_free_count       (out_free_count)
  );

  frame_alloc_checker u_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_frame             (in_frame),
    .in_is_write          (in_is_write),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_frame_index      (out_frame_index),
    .out_from_replacement (out_from_replacement),
    .out_victim_dirty     (out_victim_dirty),
    .out_status           (out_status),
    .out_free_count       (out_free_count),
    .fail_count           (fail_count),
    .pending              (pending),
    .result_count         (result_count),
    .evict_count          (evict_count),
    .dirty_count          (dirty_count),
    .reject_count         (reject_count)
  );

  // result stall: runs of no stall, sparse stall and heavy stall
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("frame_allocator_enhanced_clock_core regression: fail");
        $finish;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input logic req, input int fr, input int wr);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_frame    <= fac_pkg::FRAME_W'(fr);
    in_is_write <= wr[0];
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_frame_count(input int value);
    wait_drained();
    repeat (12) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= fac_pkg::CNT_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_done++;
    active_n = (value < 1) ? 1 : (value > fac_pkg::NUM_FRAMES) ? fac_pkg::NUM_FRAMES : value;
  endtask

  initial begin : stimulus
    int p, i, roll;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_req_type = fac_pkg::REQ_ALLOC;
    in_frame    = '0;
    in_is_write = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // four frames: rejected accesses, fill, then clean and dirty evictions
    set_frame_count(4);
    send_item(fac_pkg::REQ_ACCESS, 0, 0);
    send_item(fac_pkg::REQ_ACCESS, 63, 1);
    send_item(fac_pkg::REQ_ALLOC, 63, 1);
    send_item(fac_pkg::REQ_ALLOC, 0, 0);
    send_item(fac_pkg::REQ_ALLOC, 42, 1);
    send_item(fac_pkg::REQ_ALLOC, 21, 0);
    send_item(fac_pkg::REQ_ACCESS, 1, 1);
    send_item(fac_pkg::REQ_ACCESS, 3, 1);
    send_item(fac_pkg::REQ_ALLOC, 0, 0);
    send_item(fac_pkg::REQ_ALLOC, 0, 0);
    send_item(fac_pkg::REQ_ALLOC, 0, 0);
    send_item(fac_pkg::REQ_ACCESS, 2, 0);
    send_item(fac_pkg::REQ_ACCESS, 4, 1);
    // zero count acts as a single frame
    set_frame_count(0);
    send_item(fac_pkg::REQ_ALLOC, 0, 0);
    send_item(fac_pkg::REQ_ACCESS, 0, 1);
    send_item(fac_pkg::REQ_ALLOC, 0, 0);
    send_item(fac_pkg::REQ_ACCESS, 1, 0);
    // count above the frame total clamps to all frames
    set_frame_count(127);
    send_item(fac_pkg::REQ_ACCESS, 63, 0);
    send_item(fac_pkg::REQ_ALLOC, 0, 0);
    send_item(fac_pkg::REQ_ACCESS, 4, 1);
    send_item(fac_pkg::REQ_ACCESS, 5, 1);

    for (p = 0; p < NUM_PHASES; p++) begin
      set_frame_count(phase_count[p]);
      for (i = 0; i < phase_items[p]; i++) begin
        if (i == phase_items[p] / 2) wait_drained();
        roll = $urandom_range(0, 99);
        if (roll < 30)
          send_item(fac_pkg::REQ_ALLOC, $urandom_range(0, 63), $urandom_range(0, 1));
        else if (roll < 88)
          send_item(fac_pkg::REQ_ACCESS, $urandom_range(0, active_n - 1),
                    $urandom_range(0, 1));
        else
          send_item(fac_pkg::REQ_ACCESS, $urandom_range(0, 63), $urandom_range(0, 1));
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d requests over %0d frame-count settings", result_count,
             settings_done);
    $display("%0d clock evictions (%0d dirty), %0d rejected accesses", evict_count,
             dirty_count, reject_count);
    if (fail_count == 0)
      $display("frame_allocator_enhanced_clock_core regression: pass");
    else
      $display("frame_allocator_enhanced_clock_core regression: fail");
    $finish;
  end

endmodule
